>>> rtl/sdie_pkg.sv
// Shared types, character codes and limits for the decimal integer extractor.
package sdie_pkg;

  // Fixed field widths.
  localparam int unsigned BYTE_WIDTH  = 8;
  localparam int unsigned VALUE_WIDTH = 64;
  localparam int unsigned KEYS_WIDTH  = 32;
  localparam int unsigned DIGIT_CNT_WIDTH = 5;

  // Default width of the per-member emitted counter.
  localparam int unsigned COUNT_WIDTH_DEFAULT = 32;

  // Longest digit string that is still accepted.
  localparam logic [DIGIT_CNT_WIDTH-1:0] MAX_DIGITS = 5'd19;

  // Magnitude limits for positive and negative results.
  localparam logic [VALUE_WIDTH-1:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [VALUE_WIDTH-1:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

  // Character codes.
  localparam logic [BYTE_WIDTH-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [BYTE_WIDTH-1:0] CHAR_NINE    = 8'h39;
  localparam logic [BYTE_WIDTH-1:0] CHAR_LBRACK  = 8'h5B;
  localparam logic [BYTE_WIDTH-1:0] CHAR_RBRACK  = 8'h5D;
  localparam logic [BYTE_WIDTH-1:0] CHAR_MINUS   = 8'h2D;
  localparam logic [BYTE_WIDTH-1:0] CHAR_PLUS    = 8'h2B;
  localparam logic [BYTE_WIDTH-1:0] CHAR_NEWLINE = 8'h0A;

  // Format mode codes; the unused code behaves as plain text.
  localparam logic [1:0] FMT_CSV  = 2'd0;
  localparam logic [1:0] FMT_JSON = 2'd1;
  localparam logic [1:0] FMT_TEXT = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_FORMAT_MODE = 2'd0;
  localparam logic [1:0] REG_SKIP_HEADER = 2'd1;

  // One input request.
  typedef struct packed {
    logic [BYTE_WIDTH-1:0] data_byte;
    logic                  end_of_member;
  } item_t;

  // One result.
  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] key_value;
    logic                          key_valid;
    logic                          member_done;
    logic [KEYS_WIDTH-1:0]         keys_in_member;
  } result_t;

  // Configuration seen by the parser.
  typedef struct packed {
    logic [1:0] format_mode;
    logic       skip_header_line;
  } cfg_t;

endpackage

>>> rtl/sdie_in_stage.sv
// Input register stage holding one accepted byte request.
module sdie_in_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  sdie_pkg::item_t item,
  output logic            stage_valid,
  input  logic            stage_take,
  output sdie_pkg::item_t stage_item
);

  logic            valid;
  sdie_pkg::item_t held;

  // A new request can enter when the stage is empty or being drained.
  assign item_ready  = !valid || stage_take;
  assign stage_valid = valid;
  assign stage_item  = held;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (item_valid && item_ready) begin
      valid <= 1'b1;
    end else if (stage_take) begin
      valid <= 1'b0;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      held <= item;
    end
  end

endmodule

>>> rtl/sdie_parser.sv
// Number parser state and its update for each byte or end request.
module sdie_parser #(
  parameter int unsigned COUNT_WIDTH = sdie_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  sdie_pkg::item_t   item,
  input  sdie_pkg::cfg_t    cfg,
  output logic              push,
  output sdie_pkg::result_t result
);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // Parser state.
  logic                                   number_active;
  logic                                   is_negative;
  logic [sdie_pkg::VALUE_WIDTH-1:0]       magnitude;
  logic [sdie_pkg::DIGIT_CNT_WIDTH-1:0]   digits_seen;
  logic                                   too_large;
  logic                                   header_passed;
  logic                                   inside_brackets;
  logic [COUNT_WIDTH-1:0]                 emitted_count;

  logic                                   number_active_next;
  logic                                   is_negative_next;
  logic [sdie_pkg::VALUE_WIDTH-1:0]       magnitude_next;
  logic [sdie_pkg::DIGIT_CNT_WIDTH-1:0]   digits_seen_next;
  logic                                   too_large_next;
  logic                                   header_passed_next;
  logic                                   inside_brackets_next;
  logic [COUNT_WIDTH-1:0]                 emitted_count_next;

  logic [sdie_pkg::BYTE_WIDTH-1:0]        c;
  logic [sdie_pkg::BYTE_WIDTH-1:0]        digit_code;
  logic                                   is_digit;
  logic                                   is_sign;
  logic                                   do_scan;
  logic                                   do_close;
  logic                                   close_req;
  logic                                   start_num;
  logic                                   keep;
  logic                                   in_range;
  logic [sdie_pkg::VALUE_WIDTH-1:0]       base_mag;
  logic [sdie_pkg::DIGIT_CNT_WIDTH-1:0]   base_digits;
  logic [sdie_pkg::DIGIT_CNT_WIDTH-1:0]   digits_inc;
  logic                                   base_too_large;
  logic [sdie_pkg::VALUE_WIDTH-1:0]       mag_times_ten;
  logic [sdie_pkg::VALUE_WIDTH-1:0]       signed_val;
  logic [sdie_pkg::KEYS_WIDTH-1:0]        count_low;

  assign c          = item.data_byte;
  assign digit_code = c - sdie_pkg::CHAR_ZERO;
  assign is_digit   = (c >= sdie_pkg::CHAR_ZERO) && (c <= sdie_pkg::CHAR_NINE);
  assign is_sign    = (c == sdie_pkg::CHAR_MINUS) || (c == sdie_pkg::CHAR_PLUS);

  // Decide whether the byte is scanned, closes a number or only moves the framing.
  always_comb begin
    do_scan              = 1'b0;
    do_close             = 1'b0;
    header_passed_next   = header_passed;
    inside_brackets_next = inside_brackets;
    if (item.end_of_member) begin
      do_close = 1'b1;
    end else begin
      unique case (cfg.format_mode)
        sdie_pkg::FMT_CSV: begin
          if (cfg.skip_header_line && !header_passed) begin
            if (c == sdie_pkg::CHAR_NEWLINE) begin
              do_close           = 1'b1;
              header_passed_next = 1'b1;
            end
          end else begin
            do_scan = 1'b1;
          end
        end
        sdie_pkg::FMT_JSON: begin
          if (c == sdie_pkg::CHAR_LBRACK) begin
            inside_brackets_next = 1'b1;
          end else if (c == sdie_pkg::CHAR_RBRACK) begin
            do_close             = 1'b1;
            inside_brackets_next = 1'b0;
          end else if (inside_brackets) begin
            do_scan = 1'b1;
          end
        end
        default: begin
          do_scan = 1'b1;
        end
      endcase
    end
  end

  // Number bookkeeping: close, start and digit accumulation.
  always_comb begin
    close_req = do_close || (do_scan && number_active && !is_digit);
    start_num = do_scan && ((number_active && !is_digit && is_sign) ||
                            (!number_active && (is_digit || is_sign)));

    in_range = is_negative ? (magnitude <= sdie_pkg::NEG_LIMIT)
                           : (magnitude <= sdie_pkg::POS_LIMIT);
    keep = close_req && number_active && (digits_seen != '0) && !too_large && in_range;
    signed_val = is_negative ? (~magnitude + 64'd1) : magnitude;

    number_active_next = start_num ? 1'b1 : (close_req ? 1'b0 : number_active);
    is_negative_next   = start_num ? (c == sdie_pkg::CHAR_MINUS) : is_negative;

    base_mag       = start_num ? '0 : magnitude;
    base_digits    = start_num ? '0 : digits_seen;
    base_too_large = start_num ? 1'b0 : too_large;

    // Times ten as two shifted copies.
    mag_times_ten = {base_mag[sdie_pkg::VALUE_WIDTH-4:0], 3'b000} +
                    {base_mag[sdie_pkg::VALUE_WIDTH-2:0], 1'b0};
    digits_inc    = base_digits + 5'd1;

    magnitude_next   = base_mag;
    digits_seen_next = base_digits;
    too_large_next   = base_too_large;
    if (do_scan && is_digit && !base_too_large) begin
      digits_seen_next = digits_inc;
      if (digits_inc > sdie_pkg::MAX_DIGITS) begin
        too_large_next = 1'b1;
      end else begin
        magnitude_next = mag_times_ten +
                         {{(sdie_pkg::VALUE_WIDTH-4){1'b0}}, digit_code[3:0]};
      end
    end

    emitted_count_next = emitted_count;
    if (keep && (emitted_count != COUNT_MAX)) begin
      emitted_count_next = emitted_count + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
    end
  end

  // Reported count shows the low bits of the counter.
  generate
    if (COUNT_WIDTH >= sdie_pkg::KEYS_WIDTH) begin : g_cnt_wide
      assign count_low = emitted_count_next[sdie_pkg::KEYS_WIDTH-1:0];
    end else begin : g_cnt_narrow
      assign count_low = {{(sdie_pkg::KEYS_WIDTH-COUNT_WIDTH){1'b0}}, emitted_count_next};
    end
  endgenerate

  // Result for the output register.
  always_comb begin
    push                  = fire && (keep || item.end_of_member);
    result.key_value      = keep ? signed_val : '0;
    result.key_valid      = keep;
    result.member_done    = item.end_of_member;
    result.keys_in_member = count_low;
  end

  // State registers; an end request returns everything to reset values.
  always_ff @(posedge clk) begin
    if (rst || (fire && item.end_of_member)) begin
      number_active   <= 1'b0;
      is_negative     <= 1'b0;
      magnitude       <= '0;
      digits_seen     <= '0;
      too_large       <= 1'b0;
      header_passed   <= 1'b0;
      inside_brackets <= 1'b0;
      emitted_count   <= '0;
    end else if (fire) begin
      number_active   <= number_active_next;
      is_negative     <= is_negative_next;
      magnitude       <= magnitude_next;
      digits_seen     <= digits_seen_next;
      too_large       <= too_large_next;
      header_passed   <= header_passed_next;
      inside_brackets <= inside_brackets_next;
      emitted_count   <= emitted_count_next;
    end
  end

endmodule

>>> rtl/sdie_out_stage.sv
// Output register stage holding one result until it is taken.
module sdie_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sdie_pkg::result_t push_data,
  output logic              can_load,
  output logic              result_valid,
  input  logic              result_ready,
  output sdie_pkg::result_t result
);

  logic              valid;
  sdie_pkg::result_t held;

  // The register can take a new result when empty or when the current one leaves.
  assign can_load     = !valid || result_ready;
  assign result_valid = valid;
  assign result       = held;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (push) begin
      valid <= 1'b1;
    end else if (result_ready) begin
      valid <= 1'b0;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (push) begin
      held <= push_data;
    end
  end

endmodule

>>> rtl/streaming_decimal_integer_extractor_core.sv
// Top level of the streaming decimal integer extractor.
// The block takes one text byte (or an end-of-member request) per cycle. It returns a signed
// 64-bit integer each time an in-range decimal number completes, and one result for every
// end-of-member request, which carries the member's count.
// A request passes through an input register and is parsed by the parser state update
// (a times-ten shift-add and a range compare). The result then lands in an output
// register, which loads at the same edge at which the parser takes the request from the
// input register; a stall on the output side can hold the request there. A new request is
// accepted every cycle while the output side keeps up. Bytes that complete no number
// produce no result. Configuration writes are accepted every cycle and should be issued
// while the block is idle.
module streaming_decimal_integer_extractor_core #(
  parameter int unsigned COUNT_WIDTH = sdie_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  item_valid,
  output logic                                  item_ready,
  input  logic [sdie_pkg::BYTE_WIDTH-1:0]       data_byte,
  input  logic                                  end_of_member,
  output logic                                  result_valid,
  input  logic                                  result_ready,
  output logic signed [sdie_pkg::VALUE_WIDTH-1:0] key_value,
  output logic                                  key_valid,
  output logic                                  member_done,
  output logic [sdie_pkg::KEYS_WIDTH-1:0]       keys_in_member,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [1:0]                            cfg_index,
  input  logic [1:0]                            cfg_data
);

  sdie_pkg::item_t   in_item;
  sdie_pkg::item_t   stage_item;
  sdie_pkg::result_t parse_result;
  sdie_pkg::result_t out_result;
  sdie_pkg::cfg_t    cfg;
  logic              stage_valid;
  logic              can_load;
  logic              fire;
  logic              push;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.format_mode      <= sdie_pkg::FMT_TEXT;
      cfg.skip_header_line <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == sdie_pkg::REG_FORMAT_MODE) begin
        cfg.format_mode <= cfg_data;
      end else if (cfg_index == sdie_pkg::REG_SKIP_HEADER) begin
        cfg.skip_header_line <= cfg_data[0];
      end
    end
  end

  assign in_item.data_byte     = data_byte;
  assign in_item.end_of_member = end_of_member;

  // The parser advances whenever a request waits and the output register can load.
  assign fire = stage_valid && can_load;

  sdie_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (in_item),
    .stage_valid (stage_valid),
    .stage_take  (fire),
    .stage_item  (stage_item)
  );

  sdie_parser #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (stage_item),
    .cfg    (cfg),
    .push   (push),
    .result (parse_result)
  );

  sdie_out_stage u_out_stage (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .push_data    (parse_result),
    .can_load     (can_load),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (out_result)
  );

  assign key_value      = out_result.key_value;
  assign key_valid      = out_result.key_valid;
  assign member_done    = out_result.member_done;
  assign keys_in_member = out_result.keys_in_member;

`ifndef SYNTHESIS
  // An end-of-member request always yields a member_done result next cycle.
  a_end_result: assert property (@(posedge clk) disable iff (rst)
    (fire && stage_item.end_of_member) |=> (result_valid && member_done))
    else $error("end-of-member request produced no member_done result");

  // An empty output register never stalls the input side.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> item_ready)
    else $error("input stalled while the output register was empty");

  // A result without an integer only answers an end-of-member request.
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (push && !parse_result.key_valid) |-> stage_item.end_of_member)
    else $error("empty result pushed for a data byte");
`endif

endmodule

>>> tb/decimal_key_checker.sv
// Checker for the decimal integer extractor: tracks parser state and compares every result.
module decimal_key_checker
  import sdie_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  input  logic                          item_ready,
  input  logic [BYTE_WIDTH-1:0]         data_byte,
  input  logic                          end_of_member,
  input  logic                          result_valid,
  input  logic                          result_ready,
  input  logic signed [VALUE_WIDTH-1:0] key_value,
  input  logic                          key_valid,
  input  logic                          member_done,
  input  logic [KEYS_WIDTH-1:0]         keys_in_member,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [1:0]                    cfg_data,
  input  logic                          end_check,
  output int unsigned                   pending,
  output int unsigned                   err_count
);

  localparam int unsigned PRINT_CAP = 40;

  // Shadow copy of the configuration registers.
  logic [1:0] fmt_q;
  logic       skip_q;

  // Shadow copy of the parser state.
  logic                       num_on;
  logic                       num_neg;
  logic                       num_big;
  logic [VALUE_WIDTH-1:0]     mag;
  logic [DIGIT_CNT_WIDTH-1:0] ndigits;
  logic                       hdr_done;
  logic                       in_brackets;
  logic [COUNT_WIDTH-1:0]     member_keys;

  // Results still owed by the block, oldest first.
  result_t due_results[$];
  bit      tail_done;

  initial begin
    err_count = 0;
    pending   = 0;
    tail_done = 1'b0;
  end

  task automatic report(input string msg);
    if (err_count < PRINT_CAP) begin
      $display("%0t decimal_key_checker: %s", $time, msg);
    end
    err_count++;
  endtask

  function automatic void clear_member();
    num_on      = 1'b0;
    num_neg     = 1'b0;
    num_big     = 1'b0;
    mag         = '0;
    ndigits     = '0;
    hdr_done    = 1'b0;
    in_brackets = 1'b0;
    member_keys = '0;
  endfunction

  function automatic void open_number(input logic neg);
    num_on  = 1'b1;
    num_neg = neg;
    mag     = '0;
    ndigits = '0;
    num_big = 1'b0;
  endfunction

  // Once a number has too many digits, further digits are swallowed.
  function automatic void take_digit(input logic [BYTE_WIDTH-1:0] c);
    if (num_big) return;
    ndigits = ndigits + 1'b1;
    if (ndigits > MAX_DIGITS) begin
      num_big = 1'b1;
      return;
    end
    mag = mag * 64'd10 + {56'd0, c - CHAR_ZERO};
  endfunction

  // Closes the active number; returns 1 with its value when it is kept.
  function automatic logic close_number(output logic [VALUE_WIDTH-1:0] v);
    v = '0;
    if (!num_on) return 1'b0;
    num_on = 1'b0;
    if (ndigits == 0 || num_big) return 1'b0;
    if (!num_neg) begin
      if (mag > POS_LIMIT) return 1'b0;
      v = mag;
    end else begin
      if (mag > NEG_LIMIT) return 1'b0;
      v = ~mag + 64'd1;
    end
    if (member_keys != '1) member_keys = member_keys + 1'b1;
    return 1'b1;
  endfunction

  function automatic logic scan_char(input logic [BYTE_WIDTH-1:0] c,
                                     output logic [VALUE_WIDTH-1:0] v);
    logic digit;
    logic sign;
    logic got;
    digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    sign  = (c == CHAR_MINUS) || (c == CHAR_PLUS);
    got   = 1'b0;
    v     = '0;
    if (num_on) begin
      if (digit) begin
        take_digit(c);
      end else begin
        got = close_number(v);
        if (sign) open_number(c == CHAR_MINUS);
      end
    end else if (digit) begin
      open_number(1'b0);
      take_digit(c);
    end else if (sign) begin
      open_number(c == CHAR_MINUS);
    end
    return got;
  endfunction

  // Works out what one accepted request produces and queues it.
  function automatic void predict(input logic [BYTE_WIDTH-1:0] c, input logic eom);
    logic [VALUE_WIDTH-1:0] v;
    logic                   got;
    result_t                r;
    v   = '0;
    got = 1'b0;
    if (eom) begin
      got              = close_number(v);
      r.key_value      = v;
      r.key_valid      = got;
      r.member_done    = 1'b1;
      r.keys_in_member = KEYS_WIDTH'(member_keys);
      due_results.push_back(r);
      clear_member();
      return;
    end
    if (fmt_q == FMT_CSV) begin
      if (skip_q && !hdr_done) begin
        if (c == CHAR_NEWLINE) begin
          got      = close_number(v);
          hdr_done = 1'b1;
        end
      end else begin
        got = scan_char(c, v);
      end
    end else if (fmt_q == FMT_JSON) begin
      if (c == CHAR_LBRACK) begin
        in_brackets = 1'b1;
      end else if (c == CHAR_RBRACK) begin
        got         = close_number(v);
        in_brackets = 1'b0;
      end else if (in_brackets) begin
        got = scan_char(c, v);
      end
    end else begin
      got = scan_char(c, v);
    end
    if (got) begin
      r.key_value      = v;
      r.key_valid      = 1'b1;
      r.member_done    = 1'b0;
      r.keys_in_member = KEYS_WIDTH'(member_keys);
      due_results.push_back(r);
    end
  endfunction

  // Results are compared before the request of the same edge is predicted.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      fmt_q  = FMT_TEXT;
      skip_q = 1'b0;
      clear_member();
      due_results.delete();
      tail_done = 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (due_results.size() == 0) begin
          report($sformatf("result with no request owing it: value %0d valid %b done %b",
                           key_value, key_valid, member_done));
        end else begin
          want = due_results.pop_front();
          if (key_value !== want.key_value)
            report($sformatf("key_value %0d, expected %0d", key_value, want.key_value));
          if (key_valid !== want.key_valid)
            report($sformatf("key_valid %b, expected %b", key_valid, want.key_valid));
          if (member_done !== want.member_done)
            report($sformatf("member_done %b, expected %b", member_done, want.member_done));
          if (keys_in_member !== want.keys_in_member)
            report($sformatf("keys_in_member %0d, expected %0d",
                             keys_in_member, want.keys_in_member));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FORMAT_MODE: fmt_q  = cfg_data;
          REG_SKIP_HEADER: skip_q = cfg_data[0];
          default: ;
        endcase
      end
      if (item_valid && item_ready) predict(data_byte, end_of_member);
      if (end_check && !tail_done) begin
        tail_done = 1'b1;
        if (due_results.size() != 0)
          report($sformatf("%0d results never arrived", due_results.size()));
      end
    end
    pending = due_results.size();
  end

endmodule

>>> tb/streaming_decimal_integer_extractor_core_tb.sv
// Testbench top for the decimal integer extractor: stimulus, flow control and verdict.
module streaming_decimal_integer_extractor_core_tb;
  import sdie_pkg::*;

  localparam logic [1:0]  FMT_SPARE     = 2'd3;
  localparam logic [1:0]  REG_SPARE_LO  = 2'd2;
  localparam logic [1:0]  REG_SPARE_HI  = 2'd3;
  localparam int unsigned NUM_PHASES    = 10;
  localparam int unsigned PHASE_ITEMS   = 108;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned STALL_LIMIT   = 2000;

  logic                          clk;
  logic                          rst;
  logic                          item_valid;
  logic                          item_ready;
  logic [BYTE_WIDTH-1:0]         data_byte;
  logic                          end_of_member;
  logic                          result_valid;
  logic                          result_ready;
  logic signed [VALUE_WIDTH-1:0] key_value;
  logic                          key_valid;
  logic                          member_done;
  logic [KEYS_WIDTH-1:0]         keys_in_member;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [1:0]                    cfg_index;
  logic [1:0]                    cfg_data;
  logic                          end_check;
  int unsigned                   pending;
  int unsigned                   err_count;

  bit          idle_on;
  int unsigned stall_left;
  int unsigned quiet_cycles;
  item_t       byte_stream[$];

  streaming_decimal_integer_extractor_core u_top (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .data_byte      (data_byte),
    .end_of_member  (end_of_member),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .key_value      (key_value),
    .key_valid      (key_valid),
    .member_done    (member_done),
    .keys_in_member (keys_in_member),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  decimal_key_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .data_byte      (data_byte),
    .end_of_member  (end_of_member),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .key_value      (key_value),
    .key_valid      (key_valid),
    .member_done    (member_done),
    .keys_in_member (keys_in_member),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .end_check      (end_check),
    .pending        (pending),
    .err_count      (err_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side stalls in random bursts while idling is enabled.
  initial begin
    result_ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        result_ready = 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        result_ready = 1'b0;
        stall_left   = $urandom_range(1, 14) - 1;
      end else begin
        result_ready = 1'b1;
      end
    end
  end

  // Watchdog: ends the run when no channel moves for too long.
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("streaming_decimal_integer_extractor_core_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Numbers at and just past the limits of the signed 64-bit range, plus other 19- and 20-digit strings.
  function automatic string limit_num(input int k);
    case (k)
      0:       return "9223372036854775807";
      1:       return "9223372036854775808";
      2:       return "-9223372036854775808";
      3:       return "-9223372036854775809";
      4:       return "9999999999999999999";
      5:       return "1000000000000000000";
      6:       return "10000000000000000000";
      default: return "0000000000000000000";
    endcase
  endfunction

  task automatic push_byte(input logic [BYTE_WIDTH-1:0] b);
    item_t it;
    it.data_byte     = b;
    it.end_of_member = 1'b0;
    byte_stream.push_back(it);
  endtask

  task automatic push_end(input logic [BYTE_WIDTH-1:0] b);
    item_t it;
    it.data_byte     = b;
    it.end_of_member = 1'b1;
    byte_stream.push_back(it);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic push_digits(input int n);
    for (int i = 0; i < n; i++) push_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
  endtask

  // One random token: numbers, separators, brackets, newlines, noise, broken signs or an end request.
  task automatic add_token();
    int    pick;
    int    n;
    string seps;
    seps = " ,;:xe.\t";
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      n = $urandom_range(0, 19);
      if (n < 5) push_byte(CHAR_MINUS);
      else if (n < 8) push_byte(CHAR_PLUS);
      n = $urandom_range(0, 19);
      if (n < 16) push_digits($urandom_range(1, 6));
      else if (n < 19) push_digits($urandom_range(16, 21));
      else push_text(limit_num($urandom_range(0, 7)));
    end else if (pick < 63) begin
      push_byte(seps[$urandom_range(0, seps.len() - 1)]);
    end else if (pick < 73) begin
      push_byte($urandom_range(0, 1) ? CHAR_LBRACK : CHAR_RBRACK);
    end else if (pick < 82) begin
      push_byte(CHAR_NEWLINE);
    end else if (pick < 91) begin
      push_byte(8'($urandom_range(0, 255)));
    end else if (pick < 96) begin
      push_byte($urandom_range(0, 1) ? CHAR_MINUS : CHAR_PLUS);
      push_byte($urandom_range(0, 1) ? CHAR_MINUS : seps[0]);
    end else begin
      push_end(8'($urandom_range(0, 255)));
    end
  endtask

  // Sender may open a gap before a request; valid then holds until acceptance.
  task automatic send_item(input item_t it);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      item_valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    item_valid    = 1'b1;
    data_byte     = it.data_byte;
    end_of_member = it.end_of_member;
    do @(posedge clk); while (!item_ready);
    @(negedge clk);
  endtask

  task automatic send_all();
    while (byte_stream.size() != 0) send_item(byte_stream.pop_front());
  endtask

  // Holds off the sender until every owed result is back and the pipeline is empty.
  task automatic settle();
    item_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic configure(input logic [1:0] fmt, input logic skip);
    write_reg(REG_FORMAT_MODE, fmt);
    write_reg(REG_SKIP_HEADER, {1'($urandom_range(0, 1)), skip});
    cfg_valid = 1'b0;
  endtask

  initial begin
    logic [1:0] fmt;
    logic       skip;
    rst           = 1'b1;
    item_valid    = 1'b0;
    data_byte     = '0;
    end_of_member = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_FORMAT_MODE;
    cfg_data      = '0;
    end_check     = 1'b0;
    idle_on       = 1'b1;
    quiet_cycles  = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed opening in plain text: signs, digit extremes, sign inside a number,
    // a flush on end of member, an end with nothing pending, and extreme bytes.
    configure(FMT_TEXT, 1'b0);
    push_text("7 -0,+9-+5 3-4");
    push_end(8'hFF);
    push_end(8'h00);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(CHAR_NINE);
    push_byte(CHAR_LBRACK);
    send_all();

    // Random phases, each under its own register setting; members may span phases.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      case (ph)
        0:       begin fmt = FMT_CSV;   skip = 1'b1; end
        1:       begin fmt = FMT_CSV;   skip = 1'b0; end
        2:       begin fmt = FMT_JSON;  skip = 1'b0; end
        3:       begin fmt = FMT_JSON;  skip = 1'b1; end
        4:       begin fmt = FMT_SPARE; skip = 1'b0; end
        5:       begin fmt = FMT_CSV;   skip = 1'b1; end
        default: begin
          fmt  = 2'($urandom_range(0, 3));
          skip = 1'($urandom_range(0, 1));
        end
      endcase
      idle_on = (ph != NUM_PHASES - 1);
      configure(fmt, skip);
      if (ph == 2) begin
        // Unused register indexes must leave the setting alone.
        write_reg(REG_SPARE_LO, 2'($urandom_range(0, 3)));
        write_reg(REG_SPARE_HI, 2'($urandom_range(0, 3)));
        cfg_valid = 1'b0;
      end
      while (byte_stream.size() < PHASE_ITEMS) add_token();
      send_all();
    end

    // Drain and give the verdict.
    item_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    end_check = 1'b1;
    @(negedge clk);
    if (err_count == 0) begin
      $display("streaming_decimal_integer_extractor_core_tb: PASS");
    end else begin
      $display("streaming_decimal_integer_extractor_core_tb: FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/sdie_pkg.sv
rtl/sdie_in_stage.sv
rtl/sdie_parser.sv
rtl/sdie_out_stage.sv
rtl/streaming_decimal_integer_extractor_core.sv
tb/decimal_key_checker.sv
tb/streaming_decimal_integer_extractor_core_tb.sv
